// ===== sv/perspective_divide_viewport_map_assert.svh =====
// Assertion macros for the perspective divide and viewport map block.
`ifndef PERSPECTIVE_DIVIDE_VIEWPORT_MAP_ASSERT_SVH
`define PERSPECTIVE_DIVIDE_VIEWPORT_MAP_ASSERT_SVH

`ifndef SYNTHESIS
`define PDVM_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
`define PDVM_ASSERT_NEVER(name, cond, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);
`else
`define PDVM_ASSERT(name, prop, msg)
`define PDVM_ASSERT_NEVER(name, cond, msg)
`endif

`endif

// ===== sv/pdvm_pkg.sv =====
// Package with payload types, register indexes and saturation helper for the viewport map.
`timescale 1ns / 1ps

package pdvm_pkg;

  localparam int unsigned CoordW  = 32;
  localparam int unsigned VpW     = 14;
  localparam int unsigned CfgIdxW = 2;

  typedef logic signed [CoordW-1:0] coord_t;

  typedef struct packed {
    coord_t clip_x;
    coord_t clip_y;
    coord_t clip_z;
    coord_t clip_w;
  } vtx_in_t;

  typedef struct packed {
    coord_t screen_x;
    coord_t screen_y;
    coord_t depth_ndc;
    coord_t recip_w;
    logic   div_fault;
  } vtx_out_t;

  typedef struct packed {
    coord_t clip_x;
    coord_t clip_y;
    coord_t clip_z;
  } xyz_t;

  typedef struct packed {
    coord_t recip;
    logic   fault;
    xyz_t   xyz;
  } recip_res_t;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_VP_WIDTH  = 2'd0,
    CFG_VP_HEIGHT = 2'd1
  } cfg_idx_e;

  localparam logic [VpW-1:0] VpWidthRst  = 14'd640;
  localparam logic [VpW-1:0] VpHeightRst = 14'd480;

  localparam coord_t CoordMax = 32'sh7FFF_FFFF;
  localparam coord_t CoordMin = 32'sh8000_0000;

  localparam logic signed [63:0] QMax = 64'sh0000_0000_7FFF_FFFF;
  localparam logic signed [63:0] QMin = 64'shFFFF_FFFF_8000_0000;

  // Returns the fault flag above the clamped 32-bit value.
  function automatic logic [CoordW:0] sat32(input logic signed [63:0] v);
    logic [CoordW:0] res;
    if (v > QMax) begin
      res = {1'b1, CoordMax};
    end else if (v < QMin) begin
      res = {1'b1, CoordMin};
    end else begin
      res = {1'b0, v[CoordW-1:0]};
    end
    return res;
  endfunction

endpackage

// ===== sv/pdvm_recip.sv =====
// Pipelined restoring divider that forms the saturated fixed-point reciprocal of w.
`timescale 1ns / 1ps

module pdvm_recip #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  pdvm_pkg::coord_t     in_w_i,
  input  pdvm_pkg::xyz_t       in_xyz_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output pdvm_pkg::recip_res_t out_res_o
);

  localparam int unsigned QW = 2 * FRAC_BITS + 1;
  localparam int unsigned NS = QW + 2;
  localparam int unsigned CW = pdvm_pkg::CoordW;

  logic [NS-1:0]        v_q;
  logic [NS-1:0]        go;
  logic [CW-1:0]        mag_q  [QW];
  logic [CW-1:0]        rem_q  [1:QW-1];
  logic [QW-1:0]        quo_q  [1:QW];
  logic                 neg_q  [QW+1];
  logic                 zero_q [QW+1];
  pdvm_pkg::xyz_t       xyz_q  [QW+1];
  logic [CW-1:0]        rem_d  [1:QW-1];
  logic [QW-1:0]        quo_d  [1:QW];
  logic [CW-1:0]        rem_sh;
  logic                 ge;
  logic signed [63:0]   cand;
  logic [CW:0]          sat;
  pdvm_pkg::recip_res_t res_d;
  pdvm_pkg::recip_res_t res_q;

  always_comb begin
    go[NS-1] = !v_q[NS-1] || out_ready_i;
    for (int s = NS - 2; s >= 0; s--) begin
      go[s] = !v_q[s] || go[s+1];
    end
  end

  // The dividend is a single one bit, so only the first step shifts in a one.
  always_comb begin
    ge       = (mag_q[0] <= CW'(1));
    rem_d[1] = ge ? (CW'(1) - mag_q[0]) : CW'(1);
    quo_d[1] = QW'(ge);
    for (int s = 2; s < QW; s++) begin
      rem_sh   = {rem_q[s-1][CW-2:0], 1'b0};
      ge       = (rem_sh >= mag_q[s-1]);
      rem_d[s] = ge ? (rem_sh - mag_q[s-1]) : rem_sh;
      quo_d[s] = {quo_q[s-1][QW-2:0], ge};
    end
    rem_sh    = {rem_q[QW-1][CW-2:0], 1'b0};
    ge        = (rem_sh >= mag_q[QW-1]);
    quo_d[QW] = {quo_q[QW-1][QW-2:0], ge};
  end

  always_comb begin
    cand        = neg_q[QW] ? -$signed(64'(quo_q[QW])) : $signed(64'(quo_q[QW]));
    sat         = pdvm_pkg::sat32(cand);
    res_d.recip = zero_q[QW] ? pdvm_pkg::CoordMax : sat[CW-1:0];
    res_d.fault = zero_q[QW] | sat[CW];
    res_d.xyz   = xyz_q[QW];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (go[0]) begin
        v_q[0] <= in_valid_i;
      end
      for (int s = 1; s < NS; s++) begin
        if (go[s]) begin
          v_q[s] <= v_q[s-1];
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (go[0] && in_valid_i) begin
      mag_q[0]  <= in_w_i[CW-1] ? CW'(-in_w_i) : CW'(in_w_i);
      neg_q[0]  <= in_w_i[CW-1];
      zero_q[0] <= (in_w_i == '0);
      xyz_q[0]  <= in_xyz_i;
    end
    if (go[1] && v_q[0]) begin
      rem_q[1]  <= rem_d[1];
      quo_q[1]  <= quo_d[1];
      mag_q[1]  <= mag_q[0];
      neg_q[1]  <= neg_q[0];
      zero_q[1] <= zero_q[0];
      xyz_q[1]  <= xyz_q[0];
    end
    for (int s = 2; s < QW; s++) begin
      if (go[s] && v_q[s-1]) begin
        rem_q[s]  <= rem_d[s];
        quo_q[s]  <= quo_d[s];
        mag_q[s]  <= mag_q[s-1];
        neg_q[s]  <= neg_q[s-1];
        zero_q[s] <= zero_q[s-1];
        xyz_q[s]  <= xyz_q[s-1];
      end
    end
    if (go[QW] && v_q[QW-1]) begin
      quo_q[QW]  <= quo_d[QW];
      neg_q[QW]  <= neg_q[QW-1];
      zero_q[QW] <= zero_q[QW-1];
      xyz_q[QW]  <= xyz_q[QW-1];
    end
    if (go[NS-1] && v_q[QW]) begin
      res_q <= res_d;
    end
  end

  assign in_ready_o  = go[0];
  assign out_valid_o = v_q[NS-1];
  assign out_res_o   = res_q;

endmodule

// ===== sv/perspective_divide_viewport_map.sv =====
// Top level of the perspective divide and viewport map pipeline.
//
//   Channel   Signals                                        Direction
//   input     in_valid_i, in_ready_o, in_data_i              vertex in
//   output    out_valid_o, out_ready_i, out_data_o           result out
//   config    cfg_valid_i, cfg_ready_o, cfg_idx_i, cfg_data_i register write
//
// The block takes one vertex per clock unless the output stalls, and returns
// one result per vertex. The one-bit-per-stage reciprocal divider is followed
// by four stages for scaling, shifting with saturation, viewport map and
// clamping. Reset clears all valid bits and loads the viewport size 640 x 480.
// A full stage holds only while the next holds, so bubbles close up under a stall.
`timescale 1ns / 1ps
`include "perspective_divide_viewport_map_assert.svh"

module perspective_divide_viewport_map #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_ready_o,
  input  pdvm_pkg::vtx_in_t                  in_data_i,
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output pdvm_pkg::vtx_out_t                 out_data_o,
  input  logic                               cfg_valid_i,
  output logic                               cfg_ready_o,
  input  logic [pdvm_pkg::CfgIdxW-1:0]       cfg_idx_i,
  input  logic [pdvm_pkg::VpW-1:0]           cfg_data_i
);

  localparam int unsigned CW = pdvm_pkg::CoordW;
  localparam int unsigned AW = CW + 1 + pdvm_pkg::VpW + 1;
  localparam logic signed [CW:0] One = (CW + 1)'(64'd1 << FRAC_BITS);

  logic [pdvm_pkg::VpW-1:0] vp_w_q;
  logic [pdvm_pkg::VpW-1:0] vp_h_q;

  pdvm_pkg::xyz_t       rc_xyz;
  logic                 rc_valid;
  pdvm_pkg::recip_res_t rc_res;
  logic                 rc_bad_clamp;

  logic [3:0]           m_v_q;
  logic [3:0]           m_go;

  logic signed [63:0]   m1_px_q;
  logic signed [63:0]   m1_py_q;
  logic signed [63:0]   m1_pz_q;
  pdvm_pkg::coord_t     m1_r_q;
  logic                 m1_f_q;

  logic [CW:0]          sat_nx;
  logic [CW:0]          sat_ny;
  logic [CW:0]          sat_nz;
  pdvm_pkg::coord_t     m2_nx_q;
  pdvm_pkg::coord_t     m2_ny_q;
  pdvm_pkg::coord_t     m2_nz_q;
  pdvm_pkg::coord_t     m2_r_q;
  logic                 m2_f_q;

  logic signed [CW:0]   ox;
  logic signed [CW:0]   oy;
  logic signed [AW-1:0] m3_ax_q;
  logic signed [AW-1:0] m3_ay_q;
  pdvm_pkg::coord_t     m3_nz_q;
  pdvm_pkg::coord_t     m3_r_q;
  logic                 m3_f_q;

  logic [CW:0]          sat_sx;
  logic [CW:0]          sat_sy;
  pdvm_pkg::vtx_out_t   out_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vp_w_q <= pdvm_pkg::VpWidthRst;
      vp_h_q <= pdvm_pkg::VpHeightRst;
    end else if (cfg_valid_i) begin
      case (pdvm_pkg::cfg_idx_e'(cfg_idx_i))
        pdvm_pkg::CFG_VP_WIDTH: begin
          vp_w_q <= cfg_data_i;
        end
        pdvm_pkg::CFG_VP_HEIGHT: begin
          vp_h_q <= cfg_data_i;
        end
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    rc_xyz.clip_x = in_data_i.clip_x;
    rc_xyz.clip_y = in_data_i.clip_y;
    rc_xyz.clip_z = in_data_i.clip_z;
  end

  pdvm_recip #(
    .FRAC_BITS (FRAC_BITS)
  ) u_recip (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_w_i      (in_data_i.clip_w),
    .in_xyz_i    (rc_xyz),
    .out_valid_o (rc_valid),
    .out_ready_i (m_go[0]),
    .out_res_o   (rc_res)
  );

  always_comb begin
    m_go[3] = !m_v_q[3] || out_ready_i;
    m_go[2] = !m_v_q[2] || m_go[3];
    m_go[1] = !m_v_q[1] || m_go[2];
    m_go[0] = !m_v_q[0] || m_go[1];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_v_q <= '0;
    end else begin
      if (m_go[0]) begin
        m_v_q[0] <= rc_valid;
      end
      for (int s = 1; s < 4; s++) begin
        if (m_go[s]) begin
          m_v_q[s] <= m_v_q[s-1];
        end
      end
    end
  end

  always_comb begin
    sat_nx = pdvm_pkg::sat32(m1_px_q >>> FRAC_BITS);
    sat_ny = pdvm_pkg::sat32(m1_py_q >>> FRAC_BITS);
    sat_nz = pdvm_pkg::sat32(m1_pz_q >>> FRAC_BITS);
    ox     = {m2_nx_q[CW-1], m2_nx_q} + One;
    oy     = One - {m2_ny_q[CW-1], m2_ny_q};
    sat_sx = pdvm_pkg::sat32($signed({{(64 - AW){m3_ax_q[AW-1]}}, m3_ax_q}) >>> 1);
    sat_sy = pdvm_pkg::sat32($signed({{(64 - AW){m3_ay_q[AW-1]}}, m3_ay_q}) >>> 1);
  end

  always_ff @(posedge clk_i) begin
    if (m_go[0] && rc_valid) begin
      m1_px_q <= 64'(rc_res.xyz.clip_x) * 64'(rc_res.recip);
      m1_py_q <= 64'(rc_res.xyz.clip_y) * 64'(rc_res.recip);
      m1_pz_q <= 64'(rc_res.xyz.clip_z) * 64'(rc_res.recip);
      m1_r_q  <= rc_res.recip;
      m1_f_q  <= rc_res.fault;
    end
    if (m_go[1] && m_v_q[0]) begin
      m2_nx_q <= sat_nx[CW-1:0];
      m2_ny_q <= sat_ny[CW-1:0];
      m2_nz_q <= sat_nz[CW-1:0];
      m2_r_q  <= m1_r_q;
      m2_f_q  <= m1_f_q | sat_nx[CW] | sat_ny[CW] | sat_nz[CW];
    end
    if (m_go[2] && m_v_q[1]) begin
      m3_ax_q <= AW'(ox) * $signed({1'b0, vp_w_q});
      m3_ay_q <= AW'(oy) * $signed({1'b0, vp_h_q});
      m3_nz_q <= m2_nz_q;
      m3_r_q  <= m2_r_q;
      m3_f_q  <= m2_f_q;
    end
    if (m_go[3] && m_v_q[2]) begin
      out_q.screen_x  <= sat_sx[CW-1:0];
      out_q.screen_y  <= sat_sy[CW-1:0];
      out_q.depth_ndc <= m3_nz_q;
      out_q.recip_w   <= m3_r_q;
      out_q.div_fault <= m3_f_q | sat_sx[CW] | sat_sy[CW];
    end
  end

  assign out_valid_o = m_v_q[3];
  assign out_data_o  = out_q;

  assign rc_bad_clamp = rc_valid && !rc_res.fault && (rc_res.recip == pdvm_pkg::CoordMax);

  `PDVM_ASSERT(a_blocked_means_full, !in_ready_o |-> (rc_valid && (&m_v_q)), "stall with room")
  `PDVM_ASSERT(a_fault_carried, (m_go[1] && m_v_q[0] && m1_f_q) |=> m2_f_q, "fault dropped")
  `PDVM_ASSERT(a_out_from_stage3, $rose(out_valid_o) |-> $past(m_v_q[2]), "result without source")
  `PDVM_ASSERT_NEVER(a_max_recip_faults, rc_bad_clamp, "clamped reciprocal without fault")

endmodule
